// ===== rtl/scoped_stack_allocator_lookup_top_assert.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef SCOPED_STACK_ALLOCATOR_LOOKUP_TOP_ASSERT_SVH
`define SCOPED_STACK_ALLOCATOR_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication.
`define SSAL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SSAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ssal_pkg.sv =====
`default_nettype none

package ssal_pkg;

   localparam int OP_W    = 2;
   localparam int KEY_W   = 64;
   localparam int FIELD_W = 13;
   localparam int STAT_W  = 3;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } ssal_op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_FULL      = 3'd3,
      ST_POOL      = 3'd4
   } ssal_status_type;

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } ssal_state_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } ssal_shift_type;

endpackage

`default_nettype wire

// ===== rtl/ssal_req_if.sv =====
`default_nettype none

interface ssal_req_if;
   logic                         valid;
   logic                         ready;
   logic [ssal_pkg::OP_W-1:0]    operation;
   logic [ssal_pkg::KEY_W-1:0]   name_key;
   logic [ssal_pkg::FIELD_W-1:0] region_bytes;

   modport source (output valid, output operation, output name_key, output region_bytes,
                   input ready);
   modport sink   (input valid, input operation, input name_key, input region_bytes,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/ssal_rsp_if.sv =====
`default_nettype none

interface ssal_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ssal_pkg::STAT_W-1:0]  status;
   logic [ssal_pkg::FIELD_W-1:0] region_offset;
   logic [ssal_pkg::FIELD_W-1:0] region_size;

   modport source (output valid, output status, output region_offset, output region_size,
                   input ready);
   modport sink   (input valid, input status, input region_offset, input region_size,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/ssal_cell.sv =====
`default_nettype none

// One stack slot plus one stage of the newest-first match chain.
module ssal_cell #(
   parameter int KEY_BITS = 64,
   parameter int OFS_W    = 13,
   parameter int DEPTH_W  = 9,
   parameter int INDEX    = 0
) (
   input  logic                         clock,
   input  ssal_pkg::ssal_shift_type     shift,
   input  logic [DEPTH_W-1:0]           depth,
   input  logic [KEY_BITS-1:0]          query_key,
   input  logic [KEY_BITS-1:0]          newer_key,
   input  logic [OFS_W-1:0]             newer_ofs,
   input  logic [ssal_pkg::FIELD_W-1:0] newer_size,
   input  logic [KEY_BITS-1:0]          older_key,
   input  logic [OFS_W-1:0]             older_ofs,
   input  logic [ssal_pkg::FIELD_W-1:0] older_size,
   output logic [KEY_BITS-1:0]          own_key,
   output logic [OFS_W-1:0]             own_ofs,
   output logic [ssal_pkg::FIELD_W-1:0] own_size,
   input  logic                         chain_hit,
   input  logic [OFS_W-1:0]             chain_ofs,
   input  logic [ssal_pkg::FIELD_W-1:0] chain_size,
   output logic                         res_hit,
   output logic [OFS_W-1:0]             res_ofs,
   output logic [ssal_pkg::FIELD_W-1:0] res_size
);
   import ssal_pkg::*;

   logic [KEY_BITS-1:0] key_ff,  key_in;
   logic [OFS_W-1:0]    ofs_ff,  ofs_in;
   logic [FIELD_W-1:0]  size_ff, size_in;
   logic                hit_ff,  hit_in;
   logic [OFS_W-1:0]    rofs_ff, rofs_in;
   logic [FIELD_W-1:0]  rsize_ff, rsize_in;
   logic                live;

   always_comb begin
      key_in  = key_ff;
      ofs_in  = ofs_ff;
      size_in = size_ff;
      if (shift.push) begin
         key_in  = newer_key;
         ofs_in  = newer_ofs;
         size_in = newer_size;
      end else if (shift.pop) begin
         key_in  = older_key;
         ofs_in  = older_ofs;
         size_in = older_size;
      end
   end

   // slot holds a record only below the stack depth
   assign live = DEPTH_W'(INDEX) < depth;

   always_comb begin
      if (live && (key_ff == query_key)) begin
         hit_in   = 1'b1;
         rofs_in  = ofs_ff;
         rsize_in = size_ff;
      end else begin
         hit_in   = chain_hit;
         rofs_in  = chain_ofs;
         rsize_in = chain_size;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      ofs_ff   <= ofs_in;
      size_ff  <= size_in;
      hit_ff   <= hit_in;
      rofs_ff  <= rofs_in;
      rsize_ff <= rsize_in;
   end

   assign own_key  = key_ff;
   assign own_ofs  = ofs_ff;
   assign own_size = size_ff;
   assign res_hit  = hit_ff;
   assign res_ofs  = rofs_ff;
   assign res_size = rsize_ff;

endmodule

`default_nettype wire

// ===== rtl/scoped_stack_allocator_lookup_top.sv =====
// Push, pop and unused codes land in the response register in the cycle after the beat.
// Lookup: the response is registered once the match chain has run from the oldest cell to the top and the slot is free.
// Throughput: one push/pop request per cycle while the response slot is free; no request is taken during a lookup.
// Reset: synchronous, active high; clears stack depth, sequencer and response valid.
// Entry storage is not cleared; slots above the depth are never read.
`default_nettype none

module scoped_stack_allocator_lookup_top #(
   parameter int MAX_ENTRIES = 256,
   parameter int POOL_BYTES  = 4096,
   parameter int KEY_BITS    = 64
) (
   input  logic   clock,
   input  logic   reset,
   ssal_req_if.sink   req_chan,
   ssal_rsp_if.source rsp_chan
);
   import ssal_pkg::*;

   `include "scoped_stack_allocator_lookup_top_assert.svh"

   localparam int DEPTH_W = $clog2(MAX_ENTRIES + 1);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int OFS_W   = $clog2(POOL_BYTES + 1);
   localparam int SUM_W   = ((OFS_W > FIELD_W) ? OFS_W : FIELD_W) + 1;

   // ---------------------------------------------------------------
   // Control and payload registers
   // ---------------------------------------------------------------
   ssal_state_type      state_ff, state_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [CNT_W-1:0]    cnt_ff,   cnt_in;
   logic [KEY_BITS-1:0] qkey_ff,  qkey_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]  rsp_ofs_ff,    rsp_ofs_in;
   logic [FIELD_W-1:0]  rsp_size_ff,   rsp_size_in;

   // ---------------------------------------------------------------
   // Cell row: index 0 is the top of stack. Entries shift one slot
   // on push or pop; the match chain walks oldest -> newest, one
   // cell per cycle, so cell 0 ends up with the newest hit.
   // ---------------------------------------------------------------
   logic [KEY_BITS-1:0] cell_key  [MAX_ENTRIES];
   logic [OFS_W-1:0]    cell_ofs  [MAX_ENTRIES];
   logic [FIELD_W-1:0]  cell_size [MAX_ENTRIES];
   logic                res_hit   [MAX_ENTRIES];
   logic [OFS_W-1:0]    res_ofs   [MAX_ENTRIES];
   logic [FIELD_W-1:0]  res_size  [MAX_ENTRIES];

   ssal_shift_type      shift;
   logic [KEY_BITS-1:0] req_key;
   logic [OFS_W-1:0]    push_base;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         logic [KEY_BITS-1:0] nk, ok;
         logic [OFS_W-1:0]    no, oo;
         logic [FIELD_W-1:0]  ns, os;
         logic                ch;
         logic [OFS_W-1:0]    co;
         logic [FIELD_W-1:0]  cs;

         if (gi == 0) begin : g_head
            assign nk = req_key;
            assign no = push_base;
            assign ns = req_chan.region_bytes;
         end else begin : g_mid
            assign nk = cell_key[gi-1];
            assign no = cell_ofs[gi-1];
            assign ns = cell_size[gi-1];
         end

         if (gi == MAX_ENTRIES - 1) begin : g_tail
            // bottom slot: pop leaves it stale, chain starts as a miss
            assign ok = cell_key[gi];
            assign oo = cell_ofs[gi];
            assign os = cell_size[gi];
            assign ch = 1'b0;
            assign co = '0;
            assign cs = '0;
         end else begin : g_body
            assign ok = cell_key[gi+1];
            assign oo = cell_ofs[gi+1];
            assign os = cell_size[gi+1];
            assign ch = res_hit[gi+1];
            assign co = res_ofs[gi+1];
            assign cs = res_size[gi+1];
         end

         ssal_cell #(
            .KEY_BITS (KEY_BITS),
            .OFS_W    (OFS_W),
            .DEPTH_W  (DEPTH_W),
            .INDEX    (gi)
         ) u_cell (
            .clock      (clock),
            .shift      (shift),
            .depth      (depth_ff),
            .query_key  (qkey_ff),
            .newer_key  (nk),
            .newer_ofs  (no),
            .newer_size (ns),
            .older_key  (ok),
            .older_ofs  (oo),
            .older_size (os),
            .own_key    (cell_key[gi]),
            .own_ofs    (cell_ofs[gi]),
            .own_size   (cell_size[gi]),
            .chain_hit  (ch),
            .chain_ofs  (co),
            .chain_size (cs),
            .res_hit    (res_hit[gi]),
            .res_ofs    (res_ofs[gi]),
            .res_size   (res_size[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------
   // Request decode and push/pop arithmetic
   // ---------------------------------------------------------------
   ssal_op_type          op;
   logic                 req_fire;
   logic                 slot_free;
   logic                 cnt_done;
   logic                 stack_empty;
   logic                 stack_full;
   logic [SUM_W-1:0]     top_end;
   logic [SUM_W-1:0]     push_end;
   logic                 pool_over;
   logic [OFS_W+FIELD_W-1:0] top_ofs_x;
   logic [OFS_W+FIELD_W-1:0] base_x;
   logic [OFS_W+FIELD_W-1:0] hit_ofs_x;

   assign op          = ssal_op_type'(req_chan.operation);
   assign req_key     = req_chan.name_key[KEY_BITS-1:0];
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign cnt_done    = cnt_ff == CNT_W'(MAX_ENTRIES);
   assign stack_empty = depth_ff == '0;
   assign stack_full  = depth_ff >= DEPTH_W'(MAX_ENTRIES);

   // new region starts right after the top record, or at zero on an empty stack
   assign top_end   = SUM_W'(cell_ofs[0]) + SUM_W'(cell_size[0]);
   assign push_base = stack_empty ? '0 : top_end[OFS_W-1:0];
   assign push_end  = SUM_W'(push_base) + SUM_W'(req_chan.region_bytes);
   assign pool_over = push_end > SUM_W'(POOL_BYTES);

   // offsets leave the block as 13-bit fields
   assign top_ofs_x = {{FIELD_W{1'b0}}, cell_ofs[0]};
   assign base_x    = {{FIELD_W{1'b0}}, push_base};
   assign hit_ofs_x = {{FIELD_W{1'b0}}, res_ofs[0]};

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && op == OP_LOOKUP) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (cnt_done && slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs and datapath control
   // ---------------------------------------------------------------
   always_comb begin
      req_chan.ready = 1'b0;
      shift          = '0;
      depth_in       = depth_ff;
      cnt_in         = cnt_ff;
      qkey_in        = qkey_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_ofs_in     = rsp_ofs_ff;
      rsp_size_in    = rsp_size_ff;
      case (state_ff)
         S_IDLE: begin
            req_chan.ready = slot_free;
            if (req_fire) begin
               rsp_ofs_in  = '0;
               rsp_size_in = '0;
               case (op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (stack_full) begin
                        rsp_status_in = ST_FULL;
                     end else if (pool_over) begin
                        rsp_status_in = ST_POOL;
                     end else begin
                        rsp_status_in = ST_OK;
                        rsp_ofs_in    = base_x[FIELD_W-1:0];
                        rsp_size_in   = req_chan.region_bytes;
                        shift.push    = 1'b1;
                        depth_in      = depth_ff + DEPTH_W'(1);
                     end
                  end
                  OP_POP: begin
                     rsp_valid_in = 1'b1;
                     if (stack_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_status_in = ST_OK;
                        rsp_ofs_in    = top_ofs_x[FIELD_W-1:0];
                        rsp_size_in   = cell_size[0];
                        shift.pop     = 1'b1;
                        depth_in      = depth_ff - DEPTH_W'(1);
                     end
                  end
                  OP_LOOKUP: begin
                     qkey_in = req_key;
                     cnt_in  = '0;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (!cnt_done) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (res_hit[0]) begin
                  rsp_status_in = ST_OK;
                  rsp_ofs_in    = hit_ofs_x[FIELD_W-1:0];
                  rsp_size_in   = res_size[0];
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
                  rsp_ofs_in    = '0;
                  rsp_size_in   = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qkey_ff       <= qkey_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ofs_ff    <= rsp_ofs_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.region_offset = rsp_ofs_ff;
   assign rsp_chan.region_size   = rsp_size_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `SSAL_ASSERT_NOW(a_no_accept_in_search, clock, reset,
      state_ff == S_SEARCH, !req_chan.ready, "request taken during lookup")
   `SSAL_ASSERT_NEXT(a_push_grows, clock, reset,
      req_fire && op == OP_PUSH && !stack_full && !pool_over,
      depth_ff == $past(depth_ff) + DEPTH_W'(1), "push did not grow stack")
   `SSAL_ASSERT_NEXT(a_quick_op_responds, clock, reset,
      req_fire && op != OP_LOOKUP, rsp_valid_ff && state_ff == S_IDLE,
      "push/pop beat gave no response")
   `SSAL_ASSERT_NEXT(a_lookup_responds, clock, reset,
      state_ff == S_SEARCH && cnt_done && slot_free,
      rsp_valid_ff && state_ff == S_IDLE, "lookup finished without response")
   `SSAL_ASSERT_NOW(a_depth_bound, clock, reset,
      state_ff == S_SEARCH, depth_ff <= DEPTH_W'(MAX_ENTRIES) && cnt_ff <= CNT_W'(MAX_ENTRIES),
      "depth or search count out of range")

endmodule

`default_nettype wire

// ===== verif/tb_scoped_stack_allocator_lookup_top.sv =====
`timescale 1ns / 100ps

module tb_scoped_stack_allocator_lookup_top;
   import ssal_pkg::*;

   localparam int MAX_ENTRIES     = 256;
   localparam int POOL_BYTES      = 4096;
   localparam int KEY_BITS        = 64;
   localparam int ITEMS_PER_PHASE = 200;
   // no beat for this many cycles means the block is hung
   localparam int IDLE_LIMIT      = 5000;
   // a lookup walks every cell, so let a full walk pass before the verdict
   localparam int DRAIN_CYCLES    = MAX_ENTRIES + 16;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [FIELD_W-1:0] field_type;

   localparam field_type POOL_END = field_type'(POOL_BYTES);

   typedef struct {
      ssal_status_type status;
      field_type       offset;
      field_type       size;
   } alloc_result_type;

   // Shadow stack of variable records plus the queue of responses owed by the block.
   class alloc_scoreboard;
      key_type          entry_key [MAX_ENTRIES];
      field_type        entry_off [MAX_ENTRIES];
      field_type        entry_len [MAX_ENTRIES];
      int unsigned      depth;
      int unsigned      peak_depth;
      alloc_result_type expected_q[$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      requests;
      int unsigned      status_count[5];

      function new();
         depth      = 0;
         peak_depth = 0;
         errors     = 0;
         checked    = 0;
         requests   = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      // Apply one accepted request beat to the shadow stack and queue its response.
      function void note_request(ssal_op_type op, key_type key, field_type bytes);
         alloc_result_type res;
         int unsigned      base;
         int               idx;
         bit               found;
         res.status = ST_OK;
         res.offset = '0;
         res.size   = '0;
         found      = 1'b0;
         case (op)
            OP_PUSH: begin
               if (depth >= MAX_ENTRIES) begin
                  res.status = ST_FULL;
               end else begin
                  base = (depth == 0) ? 0 : entry_off[depth-1] + entry_len[depth-1];
                  if (base + bytes > POOL_BYTES) begin
                     res.status = ST_POOL;
                  end else begin
                     entry_key[depth] = key;
                     entry_off[depth] = field_type'(base);
                     entry_len[depth] = bytes;
                     depth++;
                     res.offset = field_type'(base);
                     res.size   = bytes;
                  end
               end
            end
            OP_POP: begin
               if (depth == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  depth--;
                  res.offset = entry_off[depth];
                  res.size   = entry_len[depth];
               end
            end
            OP_LOOKUP: begin
               for (idx = int'(depth) - 1; idx >= 0; idx--) begin
                  if (entry_key[idx] == key) begin
                     res.offset = entry_off[idx];
                     res.size   = entry_len[idx];
                     found      = 1'b1;
                     break;
                  end
               end
               if (!found) res.status = ST_NOT_FOUND;
            end
            default: ;
         endcase
         if (depth > peak_depth) peak_depth = depth;
         requests++;
         expected_q.push_back(res);
      endfunction

      function void check_response(logic [STAT_W-1:0] status, field_type offset,
                                   field_type size);
         alloc_result_type exp;
         if (expected_q.size() == 0) begin
            $error("response with nothing outstanding: status %0d offset %0d size %0d",
                   status, offset, size);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         checked++;
         status_count[exp.status]++;
         if (status !== exp.status) begin
            $error("status mismatch: expected %0d, got %0d", exp.status, status);
            errors++;
         end
         if (offset !== exp.offset) begin
            $error("region_offset mismatch: expected %0d, got %0d", exp.offset, offset);
            errors++;
         end
         if (size !== exp.size) begin
            $error("region_size mismatch: expected %0d, got %0d", exp.size, size);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ssal_req_if req_chan ();
   ssal_rsp_if rsp_chan ();

   scoped_stack_allocator_lookup_top #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .POOL_BYTES  (POOL_BYTES),
      .KEY_BITS    (KEY_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   alloc_scoreboard sb;
   key_type         key_pool [16];
   int unsigned     send_idle_pct = 0;   // chance per cycle that the sender holds off
   int unsigned     rsp_stall_pct = 0;   // chance per cycle that the receiver drops ready
   int unsigned     items_sent    = 0;
   int unsigned     idle_cycles   = 0;

   // Receiver: ready toggles at random with the current stall rate.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Response monitor: every accepted beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_response(rsp_chan.status, rsp_chan.region_offset, rsp_chan.region_size);
   end

   // Watchdog: counts cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request and hold it until the block takes the beat.
   // valid gets a single assignment per time step, so back-to-back beats keep it high.
   task automatic send_request(ssal_op_type op, key_type key, field_type bytes);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.name_key     <= key;
      req_chan.region_bytes <= bytes;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_request(op, key, bytes);
      items_sent++;
   endtask

   // Keys: mostly ones already on the stack or from a small pool so lookups hit,
   // the rest fully random to exercise every key bit.
   function automatic key_type pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30 && sb.depth > 0) return sb.entry_key[$urandom_range(0, sb.depth - 1)];
      if (r < 75) return key_pool[$urandom_range(0, 15)];
      return {$urandom(), $urandom()};
   endfunction

   // Sizes: mostly small so the stack gets deep; some large, a few past the pool.
   function automatic field_type pick_bytes();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return field_type'($urandom_range(0, 31));
      if (r < 85) return field_type'($urandom_range(0, 511));
      if (r < 95) return field_type'($urandom_range(0, POOL_BYTES));
      return field_type'($urandom_range(POOL_BYTES + 1, (1 << FIELD_W) - 1));
   endfunction

   task automatic random_request();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5)
         send_request(OP_NONE, {$urandom(), $urandom()}, field_type'($urandom()));
      else if (r < 40)
         send_request(OP_PUSH, pick_key(), pick_bytes());
      else if (r < 70)
         send_request(OP_POP, {$urandom(), $urandom()}, field_type'($urandom()));
      else
         send_request(OP_LOOKUP, pick_key(), field_type'($urandom()));
   endtask

   // Drain the stack, fill every slot with small regions, push into the full
   // table, look up a few keys at full depth, then unwind part of the way.
   task automatic fill_table();
      while (sb.depth > 0)
         send_request(OP_POP, {$urandom(), $urandom()}, field_type'($urandom()));
      for (int i = 0; i < MAX_ENTRIES + 2; i++)
         send_request(OP_PUSH, pick_key(), field_type'($urandom_range(0, 15)));
      repeat (4) send_request(OP_LOOKUP, pick_key(), field_type'($urandom()));
      repeat (MAX_ENTRIES / 2) send_request(OP_POP, '0, '0);
   endtask

   initial begin
      int unsigned phase_end;
      sb = new();
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_NONE;
      req_chan.name_key     = '0;
      req_chan.region_bytes = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = key_type'(1) << (KEY_W - 1);
      key_pool[3] = key_type'(1);
      for (int i = 4; i < 16; i++) key_pool[i] = {$urandom(), $urandom()};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: corners of every operation ----
      // empty stack: pop reports empty, lookup misses, unused code is a no-op
      send_request(OP_POP,    '1, '1);
      send_request(OP_LOOKUP, '0, '0);
      send_request(OP_NONE,   '1, '1);
      // zero-byte push, then a region spanning the whole pool
      send_request(OP_PUSH,   '1, '0);
      send_request(OP_PUSH,   '0, POOL_END);
      // zero-byte push exactly at the pool end is still accepted
      send_request(OP_PUSH,   key_pool[2], '0);
      // one byte past the end, and the largest size field
      send_request(OP_PUSH,   key_type'(1), field_type'(1));
      send_request(OP_PUSH,   key_type'(1), '1);
      // hits on the oldest and middle records, miss on an absent key
      send_request(OP_LOOKUP, '1, '0);
      send_request(OP_LOOKUP, '0, '1);
      send_request(OP_LOOKUP, key_type'(1), '0);
      // duplicate key: lookup must return the newest record
      send_request(OP_PUSH,   '1, '0);
      send_request(OP_LOOKUP, '1, '0);
      send_request(OP_NONE,   '0, '0);
      // unwind everything, one pop past empty
      repeat (5) send_request(OP_POP, '0, '0);
      // oversize on an empty stack, then a full-pool region from empty
      send_request(OP_PUSH,   key_pool[5], POOL_END + field_type'(1));
      send_request(OP_PUSH,   key_pool[5], POOL_END);
      send_request(OP_POP,    '1, '1);

      // ---- random phases with different idling ----
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         // one full-table pass in phase 1, random traffic in every phase
         if (phase == 1) fill_table();
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) random_request();
      end
      req_chan.valid <= 1'b0;

      // wait for every owed response, then let a full lookup time pass for strays
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests, checked %0d responses, peak stack depth %0d",
               sb.requests, sb.checked, sb.peak_depth);
      $display("Statuses seen: ok %0d, not found %0d, empty %0d, full %0d, pool exhausted %0d",
               sb.status_count[ST_OK], sb.status_count[ST_NOT_FOUND],
               sb.status_count[ST_EMPTY], sb.status_count[ST_FULL],
               sb.status_count[ST_POOL]);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ssal_pkg.sv
rtl/ssal_req_if.sv
rtl/ssal_rsp_if.sv
rtl/ssal_cell.sv
rtl/scoped_stack_allocator_lookup_top.sv
verif/tb_scoped_stack_allocator_lookup_top.sv
